### sv/eacu_pkg.sv
package eacu_pkg;
  localparam int MaxExtents = 64;
  localparam int IdxBits = $clog2(MaxExtents);
  localparam int CntBits = $clog2(MaxExtents + 1);
  localparam int AddrBits = 32;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam logic REG_FIT_POLICY = 1'b0;

  typedef struct packed {
    addr_t start;
    addr_t length;
  } extent_t;
endpackage

### sv/eacu_ram.sv
module eacu_ram (
  input  logic                clk,
  input  logic                wr_en,
  input  eacu_pkg::idx_t      wr_idx,
  input  eacu_pkg::extent_t   wr_data,
  input  eacu_pkg::idx_t      rd_idx,
  output eacu_pkg::extent_t   rd_data
);
  eacu_pkg::extent_t mem [eacu_pkg::MaxExtents];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end
endmodule

### sv/extent_allocator_with_coalescing_unit.sv
// Extent allocator with coalescing free table.
// A zero-length request goes straight to the done state; an allocate scans the table (best
// fit reads the whole table, then an exact fit shifts the rest down) and a free scans, then
// shifts entries up to insert (or down after merging with both neighbours).
// Throughput: one request at a time; a new beat is taken once the result beat has left.
// Reset: synchronous, active low; clears count, policy and controller, not the table.
module extent_allocator_with_coalescing_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: [31:0] req_address, [63:32] req_length
  input  logic [63:0] in_tdata,
  // tuser: [0] kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: [1:0] status, [33:2] grant_address, [39:34] zero fill
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  localparam eacu_pkg::cnt_t CntOne = eacu_pkg::cnt_t'(1);

  state_t             state_r;
  logic               policy_r;
  eacu_pkg::cnt_t     count_r;
  logic               kind_r;
  eacu_pkg::addr_t    addr_r, len_r;
  eacu_pkg::cnt_t     i_r;          // scan or shift position
  logic               found_r;
  eacu_pkg::idx_t     pick_r;
  eacu_pkg::extent_t  pick_e_r;     // chosen entry (alloc) or previous entry (free)
  logic               have_prev_r;
  logic               shift_up_r;   // free insert shifts toward higher indexes
  eacu_pkg::cnt_t     stop_r;
  eacu_pkg::extent_t  ins_r;        // value to store at the end of an up-shift
  logic               out_valid_r;
  eacu_pkg::status_t  st_r;
  eacu_pkg::addr_t    grant_r;

  logic               wr_en;
  eacu_pkg::idx_t     wr_idx, rd_idx;
  eacu_pkg::extent_t  wr_data, rd_data;

  eacu_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
    .rd_idx(rd_idx), .rd_data(rd_data)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, policy_r};
  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, grant_r, st_r};

  eacu_pkg::addr_t   prev_end, req_end;
  logic              fits;
  logic              take_now;
  logic              sel_found;
  eacu_pkg::idx_t    sel_idx;
  eacu_pkg::extent_t sel_e;
  logic              merge_prev, merge_next;
  assign prev_end = pick_e_r.start + pick_e_r.length;
  assign req_end  = addr_r + len_r;
  assign fits     = rd_data.length >= len_r;

  // When a first-fit scan stops on the entry being read, that entry is the pick.
  assign take_now  = (i_r < count_r) && fits && !found_r;
  assign sel_found = found_r || take_now;
  assign sel_idx   = take_now ? i_r[eacu_pkg::IdxBits-1:0] : pick_r;
  assign sel_e     = take_now ? rd_data : pick_e_r;

  // A freed extent touches the entry before its slot or the entry at its slot.
  assign merge_prev = have_prev_r && (prev_end == addr_r);
  assign merge_next = (i_r < count_r) && (req_end == rd_data.start);

  // Memory port control: read address and write in each state. The last write of
  // an up-shift stores the new or merged entry instead of the moved one.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = i_r[eacu_pkg::IdxBits-1:0];
    wr_data = rd_data;
    rd_idx  = i_r[eacu_pkg::IdxBits-1:0];
    unique case (state_r)
      S_SHIFT_RD: begin
        rd_idx = shift_up_r ? eacu_pkg::idx_t'(i_r - CntOne)
                            : eacu_pkg::idx_t'(i_r + CntOne);
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
        if (shift_up_r && i_r == stop_r) begin
          wr_data = ins_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == eacu_pkg::REG_FIT_POLICY) begin
        policy_r <= cfg_pwdata[0];
      end
      // A new request is taken only with no result waiting, so the done state
      // always finds the output register empty.
      if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            kind_r      <= in_tuser;
            addr_r      <= in_tdata[31:0];
            len_r       <= in_tdata[63:32];
            i_r         <= '0;
            found_r     <= 1'b0;
            have_prev_r <= 1'b0;
            grant_r     <= '0;
            if (in_tdata[63:32] == '0) begin
              st_r  <= eacu_pkg::ST_ZERO;
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          // rd_data holds entry i_r when i_r < count_r.
          if (kind_r == eacu_pkg::KIND_ALLOC) begin
            if (i_r < count_r && fits &&
                (!found_r || (policy_r && rd_data.length < pick_e_r.length))) begin
              found_r  <= 1'b1;
              pick_r   <= i_r[eacu_pkg::IdxBits-1:0];
              pick_e_r <= rd_data;
            end
            if (i_r < count_r && !(fits && !found_r && !policy_r)) begin
              i_r     <= i_r + CntOne;
              state_r <= S_READ;
            end else begin
              // Scan ends: first fit hit here, or end of table.
              if (!sel_found) begin
                st_r    <= eacu_pkg::ST_NOFIT;
                state_r <= S_DONE;
              end else begin
                st_r    <= eacu_pkg::ST_OK;
                grant_r <= sel_e.start;
                i_r     <= eacu_pkg::cnt_t'(sel_idx);
                if (sel_e.length == len_r) begin
                  shift_up_r <= 1'b0;
                  stop_r     <= count_r - CntOne;
                  count_r    <= count_r - CntOne;
                  state_r    <= S_SHIFT_RD;
                end else begin
                  ins_r      <= '{start: sel_e.start + len_r, length: sel_e.length - len_r};
                  stop_r     <= eacu_pkg::cnt_t'(sel_idx);
                  shift_up_r <= 1'b1;
                  state_r    <= S_SHIFT_WR;
                end
              end
            end
          end else begin
            if (i_r < count_r && rd_data.start <= addr_r) begin
              have_prev_r <= 1'b1;
              pick_e_r    <= rd_data;
              i_r         <= i_r + CntOne;
              state_r     <= S_READ;
            end else begin
              st_r <= eacu_pkg::ST_OK;
              if (merge_prev && merge_next) begin
                // previous grows over both; remove entry i_r by down-shift
                ins_r      <= '{start: pick_e_r.start,
                                length: pick_e_r.length + len_r + rd_data.length};
                i_r        <= i_r - CntOne;
                stop_r     <= i_r - CntOne;
                shift_up_r <= 1'b1;   // single write at stop
                count_r    <= count_r - CntOne;
                found_r    <= 1'b1;   // flags the merge-both follow-up
                state_r    <= S_SHIFT_WR;
              end else if (merge_prev) begin
                ins_r      <= '{start: pick_e_r.start, length: pick_e_r.length + len_r};
                i_r        <= i_r - CntOne;
                stop_r     <= i_r - CntOne;
                shift_up_r <= 1'b1;
                state_r    <= S_SHIFT_WR;
              end else if (merge_next) begin
                ins_r      <= '{start: addr_r, length: rd_data.length + len_r};
                stop_r     <= i_r;
                shift_up_r <= 1'b1;
                state_r    <= S_SHIFT_WR;
              end else if (count_r == eacu_pkg::cnt_t'(eacu_pkg::MaxExtents)) begin
                st_r    <= eacu_pkg::ST_FULL;
                state_r <= S_DONE;
              end else begin
                ins_r      <= '{start: addr_r, length: len_r};
                stop_r     <= i_r;
                i_r        <= count_r;
                shift_up_r <= 1'b1;
                count_r    <= count_r + CntOne;
                state_r    <= (count_r == i_r) ? S_SHIFT_WR : S_SHIFT_RD;
              end
            end
          end
        end
        S_SHIFT_RD: begin
          // Down-shift ends once i_r reaches stop_r; no read needed there.
          if (!shift_up_r && i_r >= stop_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          // The write at i_r takes the moved entry, or ins_r at the stop position.
          if (shift_up_r) begin
            if (i_r == stop_r) begin
              if (kind_r == eacu_pkg::KIND_FREE && found_r) begin
                // merge-both: now remove entry stop_r+1 by down-shift
                found_r    <= 1'b0;
                i_r        <= stop_r + CntOne;
                stop_r     <= count_r;
                shift_up_r <= 1'b0;
                state_r    <= S_SHIFT_RD;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              i_r     <= i_r - CntOne;
              state_r <= ((i_r - CntOne) == stop_r) ? S_SHIFT_WR : S_SHIFT_RD;
            end
          end else begin
            i_r     <= i_r + CntOne;
            state_r <= S_SHIFT_RD;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eacu_pkg::cnt_t'(eacu_pkg::MaxExtents))
    else $error("extent count overflow");
  a_busy_nready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("ready while busy");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != eacu_pkg::ST_OK) |-> out_tdata[33:2] == '0)
    else $error("grant on failure");
endmodule

### dv/eacu_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the extent allocator, keeps its own copy of the
// free-extent table and checks every result beat against it.
module eacu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        policy_best,
  output int          fail_count,
  output int          pending_count
);
  typedef struct packed {
    eacu_pkg::status_t status;
    eacu_pkg::addr_t   grant;
  } grant_result_t;

  eacu_pkg::addr_t ext_start [eacu_pkg::MaxExtents];
  eacu_pkg::addr_t ext_len   [eacu_pkg::MaxExtents];
  int    ext_cnt;
  grant_result_t grant_queue[$];

  function automatic grant_result_t do_allocate(eacu_pkg::addr_t len);
    int pick;
    bit found;
    grant_result_t r;
    pick = 0;
    found = 0;
    r = '{eacu_pkg::ST_OK, '0};
    for (int i = 0; i < ext_cnt; i++) begin
      if (ext_len[i] >= len) begin
        if (!found || (policy_best && ext_len[i] < ext_len[pick])) begin
          pick = i;
          found = 1;
          if (!policy_best) break;
        end
      end
    end
    if (!found) begin
      r.status = eacu_pkg::ST_NOFIT;
      return r;
    end
    r.grant = ext_start[pick];
    if (ext_len[pick] == len) begin
      for (int i = pick; i + 1 < ext_cnt; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_len[i]   = ext_len[i+1];
      end
      ext_cnt--;
    end else begin
      ext_start[pick] = ext_start[pick] + len;
      ext_len[pick]   = ext_len[pick] - len;
    end
    return r;
  endfunction

  function automatic grant_result_t do_release(eacu_pkg::addr_t addr, eacu_pkg::addr_t len);
    int pos;
    bit join_prev, join_next;
    grant_result_t r;
    pos = 0;
    join_prev = 0;
    join_next = 0;
    r = '{eacu_pkg::ST_OK, '0};
    while (pos < ext_cnt && ext_start[pos] <= addr) pos++;
    if (pos > 0) join_prev = (eacu_pkg::addr_t'(ext_start[pos-1] + ext_len[pos-1]) == addr);
    if (pos < ext_cnt) join_next = (eacu_pkg::addr_t'(addr + len) == ext_start[pos]);
    if (join_prev && join_next) begin
      ext_len[pos-1] = ext_len[pos-1] + len + ext_len[pos];
      for (int i = pos; i + 1 < ext_cnt; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_len[i]   = ext_len[i+1];
      end
      ext_cnt--;
    end else if (join_prev) begin
      ext_len[pos-1] = ext_len[pos-1] + len;
    end else if (join_next) begin
      ext_start[pos] = addr;
      ext_len[pos]   = ext_len[pos] + len;
    end else if (ext_cnt >= eacu_pkg::MaxExtents) begin
      r.status = eacu_pkg::ST_FULL;
    end else begin
      for (int i = ext_cnt; i > pos; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_len[i]   = ext_len[i-1];
      end
      ext_start[pos] = addr;
      ext_len[pos]   = len;
      ext_cnt++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    grant_result_t want;
    eacu_pkg::addr_t a, l;
    int errs;
    errs = 0;
    if (!rst_n) begin
      ext_cnt = 0;
      fail_count <= 0;
      pending_count <= 0;
      grant_queue.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        a = in_tdata[31:0];
        l = in_tdata[63:32];
        if (l == '0) want = '{eacu_pkg::ST_ZERO, '0};
        else if (in_tuser == eacu_pkg::KIND_ALLOC) want = do_allocate(l);
        else want = do_release(a, l);
        grant_queue.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (grant_queue.size() == 0) begin
          $error("result beat with no request outstanding: %h", out_tdata);
          errs++;
        end else begin
          want = grant_queue.pop_front();
          if (out_tdata[1:0] != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
            errs++;
          end
          if (out_tdata[33:2] != want.grant) begin
            $error("grant_address: expected %h, actual %h", want.grant, out_tdata[33:2]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= grant_queue.size();
    end
  end
endmodule

### dv/tb_extent_allocator_with_coalescing_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the extent allocator. The checker beside the
// block does all prediction; this module only makes request beats, APB
// writes and back-pressure.
module tb_extent_allocator_with_coalescing_unit;
  localparam int Items = 1350;
  localparam int DirectedItems = 88;
  localparam int Phases = 6;
  localparam int CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // The checker's policy follows the register write at the same edge the
  // block takes it.
  logic        policy_best = 1'b0;
  int          fail_count, pending_count;
  int          cycle_count = 0;
  bit          long_hold = 0;

  always #5 clk = ~clk;

  extent_allocator_with_coalescing_unit uut (.*);

  eacu_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .policy_best,
    .fail_count, .pending_count
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[extent_allocator_with_coalescing_unit] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, and one long hold-off while requests keep coming.
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      g = gap_len();
      out_tready <= (g == 0);
      @(posedge clk);
      if (g > 0) begin
        repeat (g - 1) @(posedge clk);
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_req(logic kind, eacu_pkg::addr_t addr, eacu_pkg::addr_t len);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {len, addr};
    @(posedge clk iff in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Block must be idle; the register is taken in the access cycle.
  task automatic write_policy(logic best);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= eacu_pkg::REG_FIT_POLICY;
    cfg_pwdata  <= {31'($urandom()), best};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    policy_best <= best;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Small lengths in a small heap keep the table busy with splits and merges.
  function automatic eacu_pkg::addr_t rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return $urandom();
    return $urandom_range(1, 64);
  endfunction

  initial begin
    eacu_pkg::addr_t base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table allocate, zero lengths, heap freed in pieces
    // that merge with the next entry and with both neighbours.
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'd16);
    send_req(eacu_pkg::KIND_FREE, 32'h100, '0);
    send_req(eacu_pkg::KIND_ALLOC, 32'hffff_ffff, '0);
    send_req(eacu_pkg::KIND_FREE, 32'h1000, 32'h100);
    send_req(eacu_pkg::KIND_FREE, 32'h1200, 32'h100);
    send_req(eacu_pkg::KIND_FREE, 32'h1100, 32'h100);
    send_req(eacu_pkg::KIND_FREE, 32'h0f00, 32'h100);
    send_req(eacu_pkg::KIND_FREE, 32'h1400, 32'h100);
    send_req(eacu_pkg::KIND_FREE, 32'h1400, 32'h10);
    send_req(eacu_pkg::KIND_ALLOC, 32'hdead_beef, 32'h100);
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'h200);
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'hffff_ffff);
    send_req(eacu_pkg::KIND_FREE, 32'hffff_ff00, 32'h100);
    send_req(eacu_pkg::KIND_FREE, 32'hffff_fff0, 32'hffff_ffff);
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'h8000_0000);
    drain();

    write_policy(1'b1);
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'h80);
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'h10);
    send_req(eacu_pkg::KIND_ALLOC, '0, 32'h10);
    // Fill the table with isolated extents until it overflows.
    for (int i = 0; i < 70; i++)
      send_req(eacu_pkg::KIND_FREE, 32'h4000_0000 + eacu_pkg::addr_t'(i) * 32'h40, 32'h20);
    drain();

    // Random phases, switching policy between them.
    for (int ph = 0; ph < Phases; ph++) begin
      write_policy(ph[0]);
      if (ph == 2) long_hold = 1;
      base = eacu_pkg::addr_t'(ph) << 29;
      send_req(eacu_pkg::KIND_FREE, base, 32'h1000);
      for (int n = 0; n < (Items - DirectedItems) / Phases - 1; n++) begin
        int r;
        eacu_pkg::addr_t l;
        r = $urandom_range(0, 99);
        l = rand_len();
        if (r < 45) begin
          send_req(eacu_pkg::KIND_ALLOC, $urandom(), l);
        end else if (r < 90) begin
          send_req(eacu_pkg::KIND_FREE, base + ($urandom_range(0, 255) * 16), l);
        end else begin
          send_req(1'($urandom_range(0, 1)), $urandom(), l);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[extent_allocator_with_coalescing_unit] OK");
    end else begin
      $display("[extent_allocator_with_coalescing_unit] ERROR");
    end
    $finish;
  end
endmodule

### extent_allocator_with_coalescing_unit.f
sv/eacu_pkg.sv
sv/eacu_ram.sv
sv/extent_allocator_with_coalescing_unit.sv
dv/eacu_checker.sv
dv/tb_extent_allocator_with_coalescing_unit.sv
